[hdl/rlmtf_pkg.sv]
package rlmtf_pkg;

  localparam int CAPACITY_DEFAULT = 10;
  localparam int KEY_BITS_DEFAULT = 32;

  localparam int FILE_KEY_W = 32;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 4;

  localparam logic KIND_ADD = 1'b0;

  typedef struct packed {
    logic compare;
    logic shift;
  } cell_ctl_t;

endpackage

[hdl/rlmtf_req_if.sv]
interface rlmtf_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [rlmtf_pkg::FILE_KEY_W-1:0] file_key;

  modport source (output valid, output kind, output file_key, input ready);
  modport sink (input valid, input kind, input file_key, output ready);
endinterface

[hdl/rlmtf_rsp_if.sv]
interface rlmtf_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             was_present;
  logic [rlmtf_pkg::POS_W-1:0]      old_position;
  logic                             evicted;
  logic [rlmtf_pkg::FILE_KEY_W-1:0] evicted_key;
  logic [rlmtf_pkg::COUNT_W-1:0]    entry_count;

  modport source (
    output valid, output was_present, output old_position, output evicted,
    output evicted_key, output entry_count, input ready
  );
  modport sink (
    input valid, input was_present, input old_position, input evicted,
    input evicted_key, input entry_count, output ready
  );
endinterface

[hdl/rlmtf_cell.sv]
module rlmtf_cell #(
  parameter int KEY_BITS = rlmtf_pkg::KEY_BITS_DEFAULT,
  parameter int IW       = 4,
  parameter int PW       = 4,
  parameter int INDEX    = 0
) (
  input  logic                 clk,
  input  rlmtf_pkg::cell_ctl_t ctl,
  input  logic [KEY_BITS-1:0]  req_key,
  input  logic [KEY_BITS-1:0]  prev_key,
  input  logic [PW-1:0]        count,
  input  logic [IW-1:0]        limit,
  output logic [KEY_BITS-1:0]  key,
  output logic                 hit
);

  logic occupied;
  logic in_range;

  assign occupied = PW'(INDEX) < count;
  assign in_range = IW'(INDEX) <= limit;

  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      hit <= occupied && (key == req_key);
    end
    if (ctl.shift && in_range) begin
      key <= prev_key;
    end
  end

endmodule

[hdl/recent_list_move_to_front.sv]
// Most-recently-used list of up to CAPACITY keys with move-to-front.
// Requests arrive on the req channel (kind, file_key); one result per request
// leaves on the rsp channel (was_present, old_position, evicted, evicted_key,
// entry_count). Both channels transfer on a clock edge with valid and ready high.
// Keys sit in a row of cells, position 0 being the most recent. Each cell
// compares its key with the request and, when told, takes its neighbor's key.
// A request moves through the idle, match and update states: the accepting edge
// latches it, the next edge registers the compare result in every cell, and the
// update edge, which waits while an earlier result is still untaken, shifts the
// row and loads the result register. A new request is accepted only after that.
// The result register lets the next request enter while a result waits; the
// shift of that next request holds until the waiting result is taken.
// A synchronous reset empties the list and drops any pending result; the key
// storage itself is not cleared, since entries beyond the count are ignored.
module recent_list_move_to_front #(
  parameter int CAPACITY = rlmtf_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS = rlmtf_pkg::KEY_BITS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  rlmtf_req_if.sink   req,
  rlmtf_rsp_if.source rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic                req_kind;
  logic [KEY_BITS-1:0] req_key;
  logic [KEY_BITS-1:0] in_key;
  logic [63:0]         in_key_wide;
  logic [PW-1:0]       held_count;
  logic [PW-1:0]       count_next;

  logic [KEY_BITS-1:0] cell_keys [CAPACITY];
  logic [CAPACITY-1:0] hits;

  rlmtf_pkg::cell_ctl_t ctl;

  logic          found;
  logic          drop;
  logic          update_en;
  logic          advance;
  logic [IW-1:0] pos;
  logic [IW-1:0] limit;
  logic [31:0]   pos_wide;
  logic [31:0]   count_wide;
  logic [63:0]   drop_wide;

  logic                                rsp_valid;
  logic                                rsp_present;
  logic [rlmtf_pkg::POS_W-1:0]         rsp_pos;
  logic                                rsp_evicted;
  logic [rlmtf_pkg::FILE_KEY_W-1:0]    rsp_key;
  logic [rlmtf_pkg::COUNT_W-1:0]       rsp_count;

  assign in_key_wide = 64'(req.file_key);
  assign in_key      = in_key_wide[KEY_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    if (i == 0) begin : g_head
      assign prev_key = req_key;
    end else begin : g_body
      assign prev_key = cell_keys[i-1];
    end
    rlmtf_cell #(
      .KEY_BITS (KEY_BITS),
      .IW       (IW),
      .PW       (PW),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .req_key  (req_key),
      .prev_key (prev_key),
      .count    (held_count),
      .limit    (limit),
      .key      (cell_keys[i]),
      .hit      (hits[i])
    );
  end

  always_comb begin
    found = |hits;
    pos   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hits[i]) begin
        pos = pos | IW'(i);
      end
    end
    drop       = 1'b0;
    limit      = pos;
    count_next = held_count;
    update_en  = found;
    if (!found && req_kind == rlmtf_pkg::KIND_ADD) begin
      update_en = 1'b1;
      if (held_count == PW'(CAPACITY)) begin
        drop  = 1'b1;
        limit = IW'(CAPACITY - 1);
      end else begin
        limit      = IW'(held_count);
        count_next = held_count + PW'(1);
      end
    end
    pos_wide   = 32'(pos);
    count_wide = 32'(count_next);
    drop_wide  = 64'(cell_keys[CAPACITY-1]);
  end

  assign advance     = (state == ST_UPDATE) && (!rsp_valid || rsp.ready);
  assign ctl.compare = (state == ST_MATCH);
  assign ctl.shift   = advance && update_en;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        held_count <= count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_kind <= req.kind;
      req_key  <= in_key;
    end
    if (advance) begin
      rsp_present <= found;
      rsp_pos     <= pos_wide[rlmtf_pkg::POS_W-1:0];
      rsp_evicted <= drop;
      rsp_key     <= drop ? drop_wide[rlmtf_pkg::FILE_KEY_W-1:0] : '0;
      rsp_count   <= count_wide[rlmtf_pkg::COUNT_W-1:0];
    end
  end

  assign req.ready        = (state == ST_IDLE) && !rst;
  assign rsp.valid        = rsp_valid;
  assign rsp.was_present  = rsp_present;
  assign rsp.old_position = rsp_pos;
  assign rsp.evicted      = rsp_evicted;
  assign rsp.evicted_key  = rsp_key;
  assign rsp.entry_count  = rsp_count;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    held_count <= PW'(CAPACITY))
    else $error("held count exceeds capacity");

  a_single_hit : assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> $onehot0(hits))
    else $error("key found at more than one position");

  a_drop_when_full : assert property (@(posedge clk) disable iff (rst)
    (advance && drop) |-> (held_count == PW'(CAPACITY)) && !found)
    else $error("eviction without a full list");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("result lost after update");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int   LIST_DEPTH    = rlmtf_pkg::CAPACITY_DEFAULT;
  localparam logic KIND_TOUCH    = ~rlmtf_pkg::KIND_ADD;
  localparam int   POOL_SIZE     = 12;
  localparam int   RANDOM_ITEMS  = 2000;
  localparam int   LONG_HOLD     = 400;
  localparam int   DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic                             was_present;
    logic [rlmtf_pkg::POS_W-1:0]      old_position;
    logic                             evicted;
    logic [rlmtf_pkg::FILE_KEY_W-1:0] evicted_key;
    logic [rlmtf_pkg::COUNT_W-1:0]    entry_count;
  } list_result_t;

  class recent_list_scoreboard;
    logic [rlmtf_pkg::FILE_KEY_W-1:0] keys [LIST_DEPTH];
    int unsigned                      held;
    list_result_t                     expected_q [$];
    int                               errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_request(input logic kind,
                               input logic [rlmtf_pkg::FILE_KEY_W-1:0] key);
      list_result_t r;
      bit           found;
      int           pos;
      int           i;
      r     = '0;
      found = 0;
      pos   = 0;
      for (i = 0; i < held; i++) begin
        if (!found && keys[i] == key) begin
          found = 1;
          pos   = i;
        end
      end
      if (found) begin
        for (i = pos; i > 0; i--) keys[i] = keys[i-1];
        keys[0] = key;
      end else if (kind == rlmtf_pkg::KIND_ADD) begin
        if (held >= LIST_DEPTH) begin
          r.evicted     = 1'b1;
          r.evicted_key = keys[LIST_DEPTH-1];
          for (i = LIST_DEPTH - 1; i > 0; i--) keys[i] = keys[i-1];
        end else begin
          for (i = held; i > 0; i--) keys[i] = keys[i-1];
          held++;
        end
        keys[0] = key;
      end
      r.was_present  = found;
      r.old_position = pos[rlmtf_pkg::POS_W-1:0];
      r.entry_count  = held[rlmtf_pkg::COUNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    task check_result(input list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.was_present !== want.was_present)
          report($sformatf("was_present %0b, want %0b", got.was_present, want.was_present));
        if (got.old_position !== want.old_position)
          report($sformatf("old_position %0d, want %0d", got.old_position,
                           want.old_position));
        if (got.evicted !== want.evicted)
          report($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report($sformatf("evicted_key %h, want %h", got.evicted_key, want.evicted_key));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, want %0d", got.entry_count,
                           want.entry_count));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  rlmtf_req_if req_ch ();
  rlmtf_rsp_if rsp_ch ();

  recent_list_move_to_front u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  recent_list_scoreboard sb = new();

  bit                               long_hold_req;
  int                               burst_left;
  logic [rlmtf_pkg::FILE_KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    list_result_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.kind, req_ch.file_key);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.was_present  = rsp_ch.was_present;
        got.old_position = rsp_ch.old_position;
        got.evicted      = rsp_ch.evicted;
        got.evicted_key  = rsp_ch.evicted_key;
        got.entry_count  = rsp_ch.entry_count;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int cyc;
    int mode;
    int hold_left;
    cyc       = 0;
    mode      = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (cyc % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic kind,
                              input logic [rlmtf_pkg::FILE_KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.file_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic [rlmtf_pkg::FILE_KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  initial begin
    logic [rlmtf_pkg::FILE_KEY_W-1:0] fill_keys [8];
    int                               n;
    int                               i;
    fill_keys = '{32'h00000001, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
                  32'h0000FFFF, 32'hFFFF0000, 32'h7FFFFFFF, 32'hFFFFFFFE};
    burst_left      = 0;
    long_hold_req   = 0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.kind     = rlmtf_pkg::KIND_ADD;
    req_ch.file_key = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(KIND_TOUCH,          32'h00000000);
    send_request(rlmtf_pkg::KIND_ADD, 32'h00000000);
    send_request(rlmtf_pkg::KIND_ADD, 32'hFFFFFFFF);
    send_request(KIND_TOUCH,          32'hFFFFFFFF);
    send_request(KIND_TOUCH,          32'h00000000);
    send_request(rlmtf_pkg::KIND_ADD, 32'h00000000);
    for (i = 0; i < 8; i++) send_request(rlmtf_pkg::KIND_ADD, fill_keys[i]);
    send_request(KIND_TOUCH,          32'h12345678);
    send_request(KIND_TOUCH,          32'hFFFFFFFF);
    send_request(rlmtf_pkg::KIND_ADD, 32'hDEADBEEF);
    send_request(rlmtf_pkg::KIND_ADD, 32'h01234567);
    send_request(rlmtf_pkg::KIND_ADD, 32'h55555555);
    send_request(KIND_TOUCH,          32'h0F0F0F0F);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        key_pool[0] = (n % 300 == 0) ? 32'h00000000 : 32'hFFFFFFFF;
      end
      if (n == 700) long_hold_req = 1;
      send_request(($urandom_range(0, 3) == 0) ? KIND_TOUCH : rlmtf_pkg::KIND_ADD,
                   pick_key());
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
